@@ rtl/core/aes_zs_pkg.sv @@
// Shared types and functions for the AES-128 zero-check encryption pipeline.
`default_nettype none
package aes_zs_pkg;

    localparam int NumRounds = 10;

    typedef logic [127:0] t_blk;

    // GF(2^8) multiply by two, modulo 0x11b
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Forward S-box as a constant table
    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] s;
        unique case (x)
            8'h00: s=8'h63; 8'h01: s=8'h7c; 8'h02: s=8'h77; 8'h03: s=8'h7b;
            8'h04: s=8'hf2; 8'h05: s=8'h6b; 8'h06: s=8'h6f; 8'h07: s=8'hc5;
            8'h08: s=8'h30; 8'h09: s=8'h01; 8'h0a: s=8'h67; 8'h0b: s=8'h2b;
            8'h0c: s=8'hfe; 8'h0d: s=8'hd7; 8'h0e: s=8'hab; 8'h0f: s=8'h76;
            8'h10: s=8'hca; 8'h11: s=8'h82; 8'h12: s=8'hc9; 8'h13: s=8'h7d;
            8'h14: s=8'hfa; 8'h15: s=8'h59; 8'h16: s=8'h47; 8'h17: s=8'hf0;
            8'h18: s=8'had; 8'h19: s=8'hd4; 8'h1a: s=8'ha2; 8'h1b: s=8'haf;
            8'h1c: s=8'h9c; 8'h1d: s=8'ha4; 8'h1e: s=8'h72; 8'h1f: s=8'hc0;
            8'h20: s=8'hb7; 8'h21: s=8'hfd; 8'h22: s=8'h93; 8'h23: s=8'h26;
            8'h24: s=8'h36; 8'h25: s=8'h3f; 8'h26: s=8'hf7; 8'h27: s=8'hcc;
            8'h28: s=8'h34; 8'h29: s=8'ha5; 8'h2a: s=8'he5; 8'h2b: s=8'hf1;
            8'h2c: s=8'h71; 8'h2d: s=8'hd8; 8'h2e: s=8'h31; 8'h2f: s=8'h15;
            8'h30: s=8'h04; 8'h31: s=8'hc7; 8'h32: s=8'h23; 8'h33: s=8'hc3;
            8'h34: s=8'h18; 8'h35: s=8'h96; 8'h36: s=8'h05; 8'h37: s=8'h9a;
            8'h38: s=8'h07; 8'h39: s=8'h12; 8'h3a: s=8'h80; 8'h3b: s=8'he2;
            8'h3c: s=8'heb; 8'h3d: s=8'h27; 8'h3e: s=8'hb2; 8'h3f: s=8'h75;
            8'h40: s=8'h09; 8'h41: s=8'h83; 8'h42: s=8'h2c; 8'h43: s=8'h1a;
            8'h44: s=8'h1b; 8'h45: s=8'h6e; 8'h46: s=8'h5a; 8'h47: s=8'ha0;
            8'h48: s=8'h52; 8'h49: s=8'h3b; 8'h4a: s=8'hd6; 8'h4b: s=8'hb3;
            8'h4c: s=8'h29; 8'h4d: s=8'he3; 8'h4e: s=8'h2f; 8'h4f: s=8'h84;
            8'h50: s=8'h53; 8'h51: s=8'hd1; 8'h52: s=8'h00; 8'h53: s=8'hed;
            8'h54: s=8'h20; 8'h55: s=8'hfc; 8'h56: s=8'hb1; 8'h57: s=8'h5b;
            8'h58: s=8'h6a; 8'h59: s=8'hcb; 8'h5a: s=8'hbe; 8'h5b: s=8'h39;
            8'h5c: s=8'h4a; 8'h5d: s=8'h4c; 8'h5e: s=8'h58; 8'h5f: s=8'hcf;
            8'h60: s=8'hd0; 8'h61: s=8'hef; 8'h62: s=8'haa; 8'h63: s=8'hfb;
            8'h64: s=8'h43; 8'h65: s=8'h4d; 8'h66: s=8'h33; 8'h67: s=8'h85;
            8'h68: s=8'h45; 8'h69: s=8'hf9; 8'h6a: s=8'h02; 8'h6b: s=8'h7f;
            8'h6c: s=8'h50; 8'h6d: s=8'h3c; 8'h6e: s=8'h9f; 8'h6f: s=8'ha8;
            8'h70: s=8'h51; 8'h71: s=8'ha3; 8'h72: s=8'h40; 8'h73: s=8'h8f;
            8'h74: s=8'h92; 8'h75: s=8'h9d; 8'h76: s=8'h38; 8'h77: s=8'hf5;
            8'h78: s=8'hbc; 8'h79: s=8'hb6; 8'h7a: s=8'hda; 8'h7b: s=8'h21;
            8'h7c: s=8'h10; 8'h7d: s=8'hff; 8'h7e: s=8'hf3; 8'h7f: s=8'hd2;
            8'h80: s=8'hcd; 8'h81: s=8'h0c; 8'h82: s=8'h13; 8'h83: s=8'hec;
            8'h84: s=8'h5f; 8'h85: s=8'h97; 8'h86: s=8'h44; 8'h87: s=8'h17;
            8'h88: s=8'hc4; 8'h89: s=8'ha7; 8'h8a: s=8'h7e; 8'h8b: s=8'h3d;
            8'h8c: s=8'h64; 8'h8d: s=8'h5d; 8'h8e: s=8'h19; 8'h8f: s=8'h73;
            8'h90: s=8'h60; 8'h91: s=8'h81; 8'h92: s=8'h4f; 8'h93: s=8'hdc;
            8'h94: s=8'h22; 8'h95: s=8'h2a; 8'h96: s=8'h90; 8'h97: s=8'h88;
            8'h98: s=8'h46; 8'h99: s=8'hee; 8'h9a: s=8'hb8; 8'h9b: s=8'h14;
            8'h9c: s=8'hde; 8'h9d: s=8'h5e; 8'h9e: s=8'h0b; 8'h9f: s=8'hdb;
            8'ha0: s=8'he0; 8'ha1: s=8'h32; 8'ha2: s=8'h3a; 8'ha3: s=8'h0a;
            8'ha4: s=8'h49; 8'ha5: s=8'h06; 8'ha6: s=8'h24; 8'ha7: s=8'h5c;
            8'ha8: s=8'hc2; 8'ha9: s=8'hd3; 8'haa: s=8'hac; 8'hab: s=8'h62;
            8'hac: s=8'h91; 8'had: s=8'h95; 8'hae: s=8'he4; 8'haf: s=8'h79;
            8'hb0: s=8'he7; 8'hb1: s=8'hc8; 8'hb2: s=8'h37; 8'hb3: s=8'h6d;
            8'hb4: s=8'h8d; 8'hb5: s=8'hd5; 8'hb6: s=8'h4e; 8'hb7: s=8'ha9;
            8'hb8: s=8'h6c; 8'hb9: s=8'h56; 8'hba: s=8'hf4; 8'hbb: s=8'hea;
            8'hbc: s=8'h65; 8'hbd: s=8'h7a; 8'hbe: s=8'hae; 8'hbf: s=8'h08;
            8'hc0: s=8'hba; 8'hc1: s=8'h78; 8'hc2: s=8'h25; 8'hc3: s=8'h2e;
            8'hc4: s=8'h1c; 8'hc5: s=8'ha6; 8'hc6: s=8'hb4; 8'hc7: s=8'hc6;
            8'hc8: s=8'he8; 8'hc9: s=8'hdd; 8'hca: s=8'h74; 8'hcb: s=8'h1f;
            8'hcc: s=8'h4b; 8'hcd: s=8'hbd; 8'hce: s=8'h8b; 8'hcf: s=8'h8a;
            8'hd0: s=8'h70; 8'hd1: s=8'h3e; 8'hd2: s=8'hb5; 8'hd3: s=8'h66;
            8'hd4: s=8'h48; 8'hd5: s=8'h03; 8'hd6: s=8'hf6; 8'hd7: s=8'h0e;
            8'hd8: s=8'h61; 8'hd9: s=8'h35; 8'hda: s=8'h57; 8'hdb: s=8'hb9;
            8'hdc: s=8'h86; 8'hdd: s=8'hc1; 8'hde: s=8'h1d; 8'hdf: s=8'h9e;
            8'he0: s=8'he1; 8'he1: s=8'hf8; 8'he2: s=8'h98; 8'he3: s=8'h11;
            8'he4: s=8'h69; 8'he5: s=8'hd9; 8'he6: s=8'h8e; 8'he7: s=8'h94;
            8'he8: s=8'h9b; 8'he9: s=8'h1e; 8'hea: s=8'h87; 8'heb: s=8'he9;
            8'hec: s=8'hce; 8'hed: s=8'h55; 8'hee: s=8'h28; 8'hef: s=8'hdf;
            8'hf0: s=8'h8c; 8'hf1: s=8'ha1; 8'hf2: s=8'h89; 8'hf3: s=8'h0d;
            8'hf4: s=8'hbf; 8'hf5: s=8'he6; 8'hf6: s=8'h42; 8'hf7: s=8'h68;
            8'hf8: s=8'h41; 8'hf9: s=8'h99; 8'hfa: s=8'h2d; 8'hfb: s=8'h0f;
            8'hfc: s=8'hb0; 8'hfd: s=8'h54; 8'hfe: s=8'hbb; 8'hff: s=8'h16;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Byte k of a block, byte 0 in the top bits
    function automatic logic [7:0] blk_byte(input t_blk b, input int k);
        blk_byte = b[127-8*k -: 8];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/aes128_encrypt_zero_sbox_check.sv @@
// Top level: AES-128 encryption pipeline with zero S-box input check.
//  channel | dir | handshake          | word
//  in      | in  | i_valid / o_ready  | key and plaintext, 256 bits
//  out     | out | o_valid / i_ready  | ciphertext and ok flag
// Eleven register stages (whitening plus ten rounds).
// One word accepted per cycle while the output word is not held.
// A held output word freezes every stage; bubbles inside are not squeezed out.
// Reset clears valid bits only.
`default_nettype none
module aes128_encrypt_zero_sbox_check
    import aes_zs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_key_high,
    input  wire logic [63:0] i_key_low,
    input  wire logic [63:0] i_text_high,
    input  wire logic [63:0] i_text_low,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_cipher_high,
    output logic [63:0]      o_cipher_low,
    output logic             o_ok
);
    localparam logic [7:0] Rcon [NumRounds] =
        '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    logic v   [NumRounds+1];
    t_blk st  [NumRounds+1];
    t_blk ky  [NumRounds+1];
    logic okv [NumRounds+1];
    logic en;

    // Advance unless the final word is held waiting
    assign en      = i_ready | ~v[NumRounds];
    assign o_ready = en;

    logic r_v0;
    t_blk r_st0, r_ky0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
        if (en) begin
            r_st0 <= {i_text_high, i_text_low} ^ {i_key_high, i_key_low};
            r_ky0 <= {i_key_high, i_key_low};
        end
    end
    assign v[0]   = r_v0;
    assign st[0]  = r_st0;
    assign ky[0]  = r_ky0;
    assign okv[0] = 1'b1;

    for (genvar r = 0; r < NumRounds; r++) begin : g_rnd
        aes_zs_round #(.LAST(r == NumRounds - 1), .RCON(Rcon[r])) u_rnd (
            .i_clk, .i_rst_n, .i_en(en),
            .i_valid(v[r]), .i_state(st[r]), .i_key(ky[r]), .i_ok(okv[r]),
            .o_valid(v[r+1]), .o_state(st[r+1]), .o_key(ky[r+1]), .o_ok(okv[r+1])
        );
    end

    assign o_valid       = v[NumRounds];
    assign o_ok          = okv[NumRounds];
    assign o_cipher_high = okv[NumRounds] ? st[NumRounds][127:64] : 64'd0;
    assign o_cipher_low  = okv[NumRounds] ? st[NumRounds][63:0]   : 64'd0;
endmodule
`default_nettype wire

@@ rtl/core/aes_zs_round.sv @@
// One pipelined AES round: key-schedule step, round transform, zero check.
`default_nettype none
module aes_zs_round
    import aes_zs_pkg::*;
#(
    parameter bit         LAST = 1'b0,
    parameter logic [7:0] RCON = 8'h01
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_blk i_state,
    input  wire t_blk i_key,
    input  wire logic i_ok,
    output logic      o_valid,
    output t_blk      o_state,
    output t_blk      o_key,
    output logic      o_ok
);
    t_blk       sub, shf, mix, nkey, n_state;
    logic [7:0] tw [4];
    logic       zero_hit;

    always_comb begin
        zero_hit = 1'b0;
        for (int k = 0; k < 16; k++) begin
            sub[127-8*k -: 8] = sbox(blk_byte(i_state, k));
            if (blk_byte(i_state, k) == 8'h00) zero_hit = 1'b1;
        end
        // RotWord then SubWord on the last key word
        for (int i = 0; i < 4; i++) begin
            tw[i] = sbox(blk_byte(i_key, 12 + ((i + 1) % 4)));
            if (blk_byte(i_key, 12 + i) == 8'h00) zero_hit = 1'b1;
        end
        tw[0] = tw[0] ^ RCON;
        nkey[127:96] = i_key[127:96] ^ {tw[0], tw[1], tw[2], tw[3]};
        nkey[95:64]  = i_key[95:64] ^ nkey[127:96];
        nkey[63:32]  = i_key[63:32] ^ nkey[95:64];
        nkey[31:0]   = i_key[31:0]  ^ nkey[63:32];
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                shf[127-8*(4*c+i) -: 8] = blk_byte(sub, ((c + i) % 4) * 4 + i);
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3;
            a0 = blk_byte(shf, 4*c);   a1 = blk_byte(shf, 4*c+1);
            a2 = blk_byte(shf, 4*c+2); a3 = blk_byte(shf, 4*c+3);
            mix[127-32*c -: 32] = {xtime(a0^a1)^a1^a2^a3, xtime(a1^a2)^a2^a3^a0,
                                   xtime(a2^a3)^a3^a0^a1, xtime(a3^a0)^a0^a1^a2};
        end
        n_state = (LAST ? shf : mix) ^ nkey;
    end

    t_blk r_state, r_key;
    logic r_valid, r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_state <= n_state;
            r_key   <= nkey;
            r_ok    <= i_ok & ~zero_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;
    assign o_ok    = r_ok;
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the AES-128 encryption pipeline with zero S-box input check.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom   = 1900;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [63:0] text_high;
        logic [63:0] text_low;
    } t_word_in;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
        logic        ok;
    } t_word_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_key_high = '0;
    logic [63:0] i_key_low = '0;
    logic [63:0] i_text_high = '0;
    logic [63:0] i_text_low = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_cipher_high;
    logic [63:0] o_cipher_low;
    logic        o_ok;

    t_word_in  pending_words[$];
    t_word_out cipher_queue[$];
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        mismatches = 0;
    int        n_checked = 0;
    int        n_failed_ok = 0;
    int        n_sent = 0;
    bit        stim_done = 1'b0;

    aes128_encrypt_zero_sbox_check u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] gmul(input logic [7:0] x, input logic [7:0] y);
        logic [8:0] a;
        logic [7:0] acc;
        a = {1'b0, x};
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (y[k]) acc ^= a[7:0];
            a = a << 1;
            if (a[8]) a ^= 9'h11b;
        end
        return acc;
    endfunction

    // inverse as x^254, then the affine map
    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [7:0] p, inv;
        p = x;
        inv = 8'h01;
        for (int k = 1; k < 8; k++) begin
            p = gmul(p, p);
            inv = gmul(inv, p);
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                   ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic t_word_out encrypt_word(input t_word_in w_in);
        logic [7:0] w[44][4];
        logic [7:0] s[16], u[16], t[4];
        logic [7:0] rc, a0, a1, a2, a3;
        logic [127:0] kb, pb, cb;
        t_word_out res;
        res = '0;
        kb = {w_in.key_high, w_in.key_low};
        pb = {w_in.text_high, w_in.text_low};
        rc = 8'h01;
        for (int j = 0; j < 4; j++)
            for (int i = 0; i < 4; i++) w[j][i] = kb[127 - 8*(4*j+i) -: 8];
        for (int j = 4; j < 44; j++) begin
            if (j % 4 != 0) begin
                for (int i = 0; i < 4; i++) t[i] = w[j-1][i];
            end else begin
                for (int i = 0; i < 4; i++) begin
                    if (w[j-1][(i+1)%4] == 8'h00) return res;
                    t[i] = sub_byte(w[j-1][(i+1)%4]);
                end
                t[0] ^= rc;
                rc = gmul(rc, 8'h02);
            end
            for (int i = 0; i < 4; i++) w[j][i] = t[i] ^ w[j-4][i];
        end
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) s[4*c+i] = pb[127 - 8*(4*c+i) -: 8] ^ w[c][i];
        for (int r = 0; r < 10; r++) begin
            for (int i = 0; i < 16; i++) begin
                if (s[i] == 8'h00) return res;
                u[i] = sub_byte(s[i]);
            end
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) s[4*c+i] = u[((c+i)%4)*4+i];
            if (r < 9) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = gmul(a0 ^ a1, 8'h02) ^ a1 ^ a2 ^ a3;
                    s[4*c+1] = gmul(a1 ^ a2, 8'h02) ^ a2 ^ a3 ^ a0;
                    s[4*c+2] = gmul(a2 ^ a3, 8'h02) ^ a3 ^ a0 ^ a1;
                    s[4*c+3] = gmul(a3 ^ a0, 8'h02) ^ a0 ^ a1 ^ a2;
                end
            end
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) s[4*c+i] ^= w[4*r+4+c][i];
        end
        for (int k = 0; k < 16; k++) cb[127 - 8*k -: 8] = s[k];
        res.cipher_high = cb[127:64];
        res.cipher_low  = cb[63:0];
        res.ok = 1'b1;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // zero-free bytes give deep runs; this function never yields a zero byte
    function automatic logic [63:0] rand_nz64();
        logic [63:0] v;
        for (int k = 0; k < 8; k++) v[8*k +: 8] = 8'($urandom_range(1, 255));
        return v;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) n_sent <= n_sent + 1;
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                t_word_in w;
                w = pending_words.pop_front();
                i_key_high  <= w.key_high;
                i_key_low   <= w.key_low;
                i_text_high <= w.text_high;
                i_text_low  <= w.text_low;
                i_valid     <= 1'b1;
                cipher_queue = {cipher_queue, encrypt_word(w)};
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                t_word_out got, want;
                got = '{o_cipher_high, o_cipher_low, o_ok};
                if (cipher_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", got);
                end else begin
                    want = cipher_queue.pop_front();
                    n_checked++;
                    if (!want.ok) n_failed_ok++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h %h ok=%b got %h %h ok=%b",
                                     want.cipher_high, want.cipher_low, want.ok,
                                     got.cipher_high, got.cipher_low, got.ok);
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        t_word_in w;
        int total;
        // directed: known-answer vectors, all-zero, all-ones, key and text of opposite fill, zero in a single byte
        w = '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
              64'h3243f6a8885a308d, 64'h313198a2e0370734};
        pending_words = {pending_words, w};
        w = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
              64'h0011223344556677, 64'h8899aabbccddeeff};
        pending_words = {pending_words, w};
        w = '0;
        pending_words = {pending_words, w};
        w = '1;
        pending_words = {pending_words, w};
        w = '{'1, '1, '0, '0};
        pending_words = {pending_words, w};
        w = '{'0, '0, '1, '1};
        pending_words = {pending_words, w};
        for (int k = 0; k < 16; k++) begin
            w = '{rand_nz64(), rand_nz64(), rand_nz64(), rand_nz64()};
            if (k < 8) begin
                // zero key byte; for k < 4 it is in the rotated word feeding the key schedule S-box
                w.key_low[8*k +: 8] = 8'h00;
            end else begin
                // plaintext byte equal to key byte: zero state byte in round one
                w.text_high[8*(k-8) +: 8] = w.key_high[8*(k-8) +: 8];
            end
            pending_words = {pending_words, w};
        end
        for (int k = 0; k < NumRandom; k++) begin
            if ($urandom_range(0, 9) < 8)
                w = '{rand_nz64(), rand_nz64(), rand_nz64(), rand_nz64()};
            else
                w = '{rand64(), rand64(), rand64(), rand64()};
            pending_words = {pending_words, w};
        end
        total = pending_words.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            wait (n_sent >= (total * (ph + 1)) / 4 || pending_words.size() == 0);
            @(posedge i_clk);
        end
        wait (pending_words.size() == 0 && !(i_valid && !o_ready));
        stall_pct = 0;
        wait (cipher_queue.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("checked %0d words, %0d with a zero S-box input", n_checked, n_failed_ok);
        $display("idle and stall phases: none, sender, receiver, both");
        if (mismatches == 0 && cipher_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
